### design/hsfd_pkg.sv
// Shared types, constants and CRC function of the humidity sensor frame decoder.
`default_nettype none

package hsfd_pkg;

  // Byte positions within the six-byte frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling constants: 175.00 degrees span, -45.00 offset, 100.00 percent span
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
    logic        [15:0] raw_temperature;
    logic        [15:0] raw_humidity;
    logic        [1:0]  crc_status;
  } out_t;

  // One assembled frame handed from front to back
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic [1:0]  crc_status;
  } frame_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/hsfd_front.sv
// Front part: tracks byte position, checks CRCs and assembles frames.
`default_nettype none

module hsfd_front
  import hsfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_t       byte_item,
  output logic           frame_valid,
  output frame_t         frame
);

  pos_t       pos, pos_next, eff_pos;
  logic [7:0] crc, crc_next;
  logic       t_bad, t_bad_next;
  logic [7:0] high_byte, high_byte_next;
  logic [15:0] t_word, t_word_next;
  logic [15:0] h_word, h_word_next;
  logic [7:0] b;

  assign b = byte_item.data_byte;

  // Hold position and CRC state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_T_HI;
      crc   <= CRC_INIT;
      t_bad <= 1'b0;
    end else begin
      pos   <= pos_next;
      crc   <= crc_next;
      t_bad <= t_bad_next;
    end
  end

  // Hold assembled words
  always_ff @(posedge clk) begin
    high_byte <= high_byte_next;
    t_word    <= t_word_next;
    h_word    <= h_word_next;
  end

  // Advance position on each transfer; frame_start restarts the frame
  always_comb begin
    eff_pos        = byte_item.frame_start ? POS_T_HI : pos;
    pos_next       = pos;
    crc_next       = crc;
    t_bad_next     = t_bad;
    high_byte_next = high_byte;
    t_word_next    = t_word;
    h_word_next    = h_word;
    frame_valid    = 1'b0;
    frame.raw_temperature = t_word;
    frame.raw_humidity    = h_word;
    frame.crc_status      = {b != crc, t_bad};
    if (accept) begin
      unique case (eff_pos)
        POS_T_HI, POS_H_HI: begin
          crc_next       = crc8_byte(CRC_INIT, b);
          high_byte_next = b;
          pos_next       = (eff_pos == POS_T_HI) ? POS_T_LO : POS_H_LO;
        end
        POS_T_LO: begin
          crc_next    = crc8_byte(crc, b);
          t_word_next = {high_byte, b};
          pos_next    = POS_T_CRC;
        end
        POS_T_CRC: begin
          t_bad_next = (b != crc);
          crc_next   = CRC_INIT;
          pos_next   = POS_H_HI;
        end
        POS_H_LO: begin
          crc_next    = crc8_byte(crc, b);
          h_word_next = {high_byte, b};
          pos_next    = POS_H_CRC;
        end
        POS_H_CRC: begin
          frame_valid = 1'b1;
          crc_next    = CRC_INIT;
          pos_next    = POS_T_HI;
        end
        default: begin
          pos_next = POS_T_HI;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/hsfd_queue.sv
// Short frame queue between the front and back parts.
`default_nettype none

module hsfd_queue
  import hsfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_en,
  input  wire frame_t push_data,
  input  wire logic   pop_en,
  output frame_t      pop_data,
  output q_status_t   status
);

  frame_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_push, do_pop;

  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push_en && !status.full;
  assign do_pop       = pop_en && !status.empty;
  assign pop_data     = entries[rd_ptr];

  // Store pushed frames
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/hsfd_back.sv
// Back part: scales raw words in a two-stage pipeline and presents results.
`default_nettype none

module hsfd_back
  import hsfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t q_status,
  input  wire frame_t    frame,
  output logic           take,
  input  wire logic      pop,
  output logic           empty,
  output out_t           result
);

  logic        s1_valid, s2_valid;
  logic        s1_ready, s2_ready;
  logic [30:0] t_prod;
  logic [29:0] h_prod;
  frame_t      s1_frame;
  logic [31:0] t_sum, h_sum;
  logic [14:0] t_q;
  logic [13:0] h_q;

  assign s2_ready = !s2_valid || pop;
  assign s1_ready = !s1_valid || s2_ready;
  assign take     = s1_ready && !q_status.empty;
  assign empty    = !s2_valid;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= !q_status.empty;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Stage 1: multiply raw words by their spans
  always_ff @(posedge clk) begin
    if (take) begin
      t_prod   <= 31'(frame.raw_temperature) * 31'(TEMP_SPAN);
      h_prod   <= 30'(frame.raw_humidity) * 30'(HUM_SPAN);
      s1_frame <= frame;
    end
  end

  // Divide by 65535: floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for these ranges
  always_comb begin
    t_sum = 32'(t_prod) + 32'(t_prod[30:16]) + 32'd1;
    h_sum = 32'(h_prod) + 32'(h_prod[29:16]) + 32'd1;
    t_q   = t_sum[30:16];
    h_q   = h_sum[29:16];
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      result.temperature_centi <= $signed(t_q - TEMP_OFFSET);
      result.humidity_centi    <= h_q;
      result.raw_temperature   <= s1_frame.raw_temperature;
      result.raw_humidity      <= s1_frame.raw_humidity;
      result.crc_status        <= s1_frame.crc_status;
    end
  end

endmodule

`default_nettype wire

### design/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder.
//
// Input queue side: byte_item carries one received frame byte; it transfers
// on a rising edge with push high and full low. Bytes arrive in order
// temperature high, low, CRC, humidity high, low, CRC; frame_start set on a
// byte restarts the frame at that byte.
// Result queue side: result holds the oldest decoded frame while empty is
// low; it transfers on a rising edge with pop high.
// One byte per cycle is taken while full is low. The sixth byte of a frame
// lands in a two-entry frame queue at its transfer edge; from there the
// result passes the multiply stage, then the divide-by-65535 correction into
// the result register, when the result side is not stalled.
// While the result side stalls, frames collect in the result register, the
// multiply stage and the frame queue; once the queue holds two frames, full
// rises and no byte is taken until pop frees space.
// Reset (rst, synchronous) empties the pipeline and queue and returns the
// byte position to the first byte with the CRC at 0xFF.
`default_nettype none

module humidity_sensor_frame_decoder
  import hsfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  byte_item,
  output logic      empty,
  input  wire logic pop,
  output out_t      result
);

  logic      accept;
  logic      frame_valid;
  frame_t    frame_in, frame_out;
  logic      take;
  q_status_t q_status;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  hsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_item  (byte_item),
    .frame_valid(frame_valid),
    .frame      (frame_in)
  );

  hsfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_en  (frame_valid),
    .push_data(frame_in),
    .pop_en   (take),
    .pop_data (frame_out),
    .status   (q_status)
  );

  hsfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_status(q_status),
    .frame   (frame_out),
    .take    (take),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

### design/hsfd_checker.sv
// Port-level checker for the humidity sensor frame decoder, bound to the top.
`default_nettype none

module hsfd_checker
  import hsfd_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire out_t result
);

  // Reset drains everything
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or queue not empty after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  // Humidity stays within its scale
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.humidity_centi <= 14'd10000))
    else $error("humidity out of range");

  // Temperature stays within its scale
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.temperature_centi >= -15'sd4500 &&
                result.temperature_centi <= 15'sd13000))
    else $error("temperature out of range");

  // Raw humidity word zero gives zero humidity
  a_hum_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.raw_humidity == 16'd0) |-> (result.humidity_centi == 14'd0))
    else $error("humidity scaling wrong at zero");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result   (result)
);

`default_nettype wire

### dv/tb_humidity_sensor_frame_decoder.sv
// Self-checking testbench for the humidity sensor frame decoder: directed frames, then random ones.
`timescale 1ns / 100ps

module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  // CRC status codes carried in each decoded frame
  localparam logic [1:0] CRC_OK       = 2'd0;
  localparam logic [1:0] CRC_TEMP_BAD = 2'd1;
  localparam logic [1:0] CRC_HUM_BAD  = 2'd2;
  localparam logic [1:0] CRC_BOTH_BAD = 2'd3;

  localparam logic [8:0]  CRC_POLY_FULL = 9'h131;
  localparam logic [31:0] FULL_SCALE    = 32'd65535;
  localparam int          RANDOM_BYTES  = 1800;
  localparam int          LONG_HOLD     = 300;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef struct {
    logic [7:0] data_byte;
    logic       frame_start;
    bit         typed;
    out_t       want;
  } stim_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic push      = 1'b0;
  logic pop       = 1'b0;
  in_t  byte_item = '0;
  logic full;
  logic empty;
  out_t result;

  // Predictor state
  pos_t        frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  high_byte_hold;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        temp_crc_err;

  out_t      decoded_frames_q[$];
  stim_row_t frame_stim_rows[$];
  int        error_count   = 0;
  int        bytes_sent    = 0;
  int        frames_popped = 0;
  int        cycle_count   = 0;
  bit        tx_idle       = 1'b1;
  bit        rx_idle       = 1'b1;

  humidity_sensor_frame_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // CRC-8, polynomial 0x31, MSB first, one byte
  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] b);
    logic [8:0] r;
    r = {1'b0, acc ^ b};
    repeat (8) begin
      r = r << 1;
      if (r[8]) r = r ^ CRC_POLY_FULL;
    end
    return r[7:0];
  endfunction

  // Advance the frame state by one byte; return 1 when a frame completes
  function automatic bit predict_frame_byte(in_t item, output out_t res);
    logic [2:0]  pos;
    logic [31:0] t_scaled;
    logic [31:0] h_scaled;
    pos = frame_pos;
    res = '0;
    if (item.frame_start || pos > POS_H_CRC) pos = POS_T_HI;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_acc        = crc8_step(CRC_INIT, item.data_byte);
        high_byte_hold = item.data_byte;
        frame_pos      = pos_t'(pos + 3'd1);
        return 1'b0;
      end
      POS_T_LO: begin
        crc_acc   = crc8_step(crc_acc, item.data_byte);
        temp_word = {high_byte_hold, item.data_byte};
        frame_pos = POS_T_CRC;
        return 1'b0;
      end
      POS_T_CRC: begin
        temp_crc_err = (item.data_byte != crc_acc);
        crc_acc      = CRC_INIT;
        frame_pos    = POS_H_HI;
        return 1'b0;
      end
      POS_H_LO: begin
        crc_acc   = crc8_step(crc_acc, item.data_byte);
        hum_word  = {high_byte_hold, item.data_byte};
        frame_pos = POS_H_CRC;
        return 1'b0;
      end
      default: begin
        t_scaled = (32'(TEMP_SPAN) * 32'(temp_word)) / FULL_SCALE;
        h_scaled = (32'(HUM_SPAN) * 32'(hum_word)) / FULL_SCALE;
        res.temperature_centi = 15'(int'(t_scaled) - int'(TEMP_OFFSET));
        res.humidity_centi    = h_scaled[13:0];
        res.raw_temperature   = temp_word;
        res.raw_humidity      = hum_word;
        res.crc_status        = {item.data_byte != crc_acc, temp_crc_err};
        frame_pos = POS_T_HI;
        crc_acc   = CRC_INIT;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic add_row(logic [7:0] b, logic fs, bit typed, int temp, int hum,
                         logic [15:0] rt, logic [15:0] rh, logic [1:0] st);
    stim_row_t row;
    row.data_byte              = b;
    row.frame_start            = fs;
    row.typed                  = typed;
    row.want.temperature_centi = 15'(temp);
    row.want.humidity_centi    = 14'(hum);
    row.want.raw_temperature   = rt;
    row.want.raw_humidity      = rh;
    row.want.crc_status        = st;
    frame_stim_rows.push_back(row);
  endtask

  // Offer one byte, wait for its transfer, then queue what it should produce
  task automatic send_byte(logic [7:0] b, logic fs, bit typed, out_t want);
    in_t  item;
    out_t pred;
    bit   has_frame;
    int   gap;
    item.data_byte   = b;
    item.frame_start = fs;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    byte_item <= item;
    do @(posedge clk); while (full);
    bytes_sent++;
    has_frame = predict_frame_byte(item, pred);
    if (typed) decoded_frames_q.push_back(want);
    else if (has_frame) decoded_frames_q.push_back(pred);
    if ($urandom_range(0, 99) == 0) tx_idle = !tx_idle;
  endtask

  function automatic logic [15:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Send one six-byte frame with random content; corrupt CRCs now and then
  task automatic send_random_frame(logic fs);
    logic [15:0] words[2];
    logic [7:0]  crc_byte;
    out_t        none;
    none = '0;
    words[0] = draw_word();
    words[1] = draw_word();
    for (int w = 0; w < 2; w++) begin
      crc_byte = crc8_step(crc8_step(CRC_INIT, words[w][15:8]), words[w][7:0]);
      if ($urandom_range(0, 5) == 0) crc_byte = crc_byte ^ 8'($urandom_range(1, 255));
      send_byte(words[w][15:8], (w == 0) ? fs : 1'b0, 1'b0, none);
      send_byte(words[w][7:0], 1'b0, 1'b0, none);
      send_byte(crc_byte, 1'b0, 1'b0, none);
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (decoded_frames_q.size() == 0) begin
      $error("unexpected result: raw_temperature %0h raw_humidity %0h",
             got.raw_temperature, got.raw_humidity);
      error_count++;
      return;
    end
    want = decoded_frames_q.pop_front();
    if (got.temperature_centi !== want.temperature_centi) begin
      $error("temperature_centi: expected %0d, got %0d",
             $signed(want.temperature_centi), $signed(got.temperature_centi));
      error_count++;
    end
    if (got.humidity_centi !== want.humidity_centi) begin
      $error("humidity_centi: expected %0d, got %0d", want.humidity_centi, got.humidity_centi);
      error_count++;
    end
    if (got.raw_temperature !== want.raw_temperature) begin
      $error("raw_temperature: expected %0h, got %0h",
             want.raw_temperature, got.raw_temperature);
      error_count++;
    end
    if (got.raw_humidity !== want.raw_humidity) begin
      $error("raw_humidity: expected %0h, got %0h", want.raw_humidity, got.raw_humidity);
      error_count++;
    end
    if (got.crc_status !== want.crc_status) begin
      $error("crc_status: expected %0d, got %0d", want.crc_status, got.crc_status);
      error_count++;
    end
  endtask

  // Result side: random stalls, plus two long holds to back the block up
  task automatic run_receiver();
    int stall;
    forever begin
      stall = rx_idle ? $urandom_range(0, 4) : 0;
      if (frames_popped == 30 || frames_popped == 200) stall = LONG_HOLD;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      frames_popped++;
      check_result(result);
      if ($urandom_range(0, 49) == 0) rx_idle = !rx_idle;
    end
  endtask

  initial begin : main
    frame_pos      = POS_T_HI;
    crc_acc        = CRC_INIT;
    high_byte_hold = '0;
    temp_word      = '0;
    hum_word       = '0;
    temp_crc_err   = 1'b0;

    // Extremes with both CRCs wrong: coldest, wettest
    add_row(8'h00, 1'b1, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 1, -4500, 10000, 16'h0000, 16'hFFFF, CRC_BOTH_BAD);
    // Hottest, driest; humidity CRC wrong
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hAC, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 1, 13000, 0, 16'hFFFF, 16'h0000, CRC_HUM_BAD);
    // Coldest, wettest; temperature CRC wrong
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h00, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h7E, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hFF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hAC, 1'b0, 1, -4500, 10000, 16'h0000, 16'hFFFF, CRC_TEMP_BAD);
    // Partial frame dropped by a resync, then a clean mid-range frame
    add_row(8'h55, 1'b1, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hAA, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hBE, 1'b1, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hEF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h92, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hBE, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'hEF, 1'b0, 0, 0, 0, '0, '0, CRC_OK);
    add_row(8'h92, 1'b0, 1, 8552, 7458, 16'hBEEF, 16'hBEEF, CRC_OK);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      run_receiver();
    join_none

    // Directed part
    foreach (frame_stim_rows[i]) begin
      send_byte(frame_stim_rows[i].data_byte, frame_stim_rows[i].frame_start,
                frame_stim_rows[i].typed, frame_stim_rows[i].want);
    end

    // Random part: mostly whole frames, some stray bytes and cut-off frames
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
        end
        send_random_frame(1'b1);
      end else begin
        send_random_frame(1'($urandom_range(0, 1)));
      end
    end
    push <= 1'b0;

    // Drain the pipeline
    while (decoded_frames_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### humidity_sensor_frame_decoder.f
design/hsfd_pkg.sv
design/hsfd_front.sv
design/hsfd_queue.sv
design/hsfd_back.sv
design/humidity_sensor_frame_decoder.sv
design/hsfd_checker.sv
dv/tb_humidity_sensor_frame_decoder.sv
